/* sv/fgfq_pkg.sv */
// Shared types and constants for the free gap fit query unit.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package fgfq_pkg;

   localparam int POSITIONS_DEF = 1024;
   localparam int POS_W         = 10;
   localparam int SIZE_W        = 10;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PC_RD,
      ST_PC_EV,
      ST_DN_RD,
      ST_DN_EV,
      ST_WR_P,
      ST_UP_RD,
      ST_UP_EV,
      ST_WR_S,
      ST_Q_RD,
      ST_Q_EV,
      ST_RESP
   } state_type;

   typedef enum logic [2:0] {
      IDX_HOLD,
      IDX_ZERO,
      IDX_POS,
      IDX_POS_M1,
      IDX_POS_P1,
      IDX_INC,
      IDX_DEC
   } idx_op_type;

   typedef enum logic [1:0] {
      WR_ZERO,
      WR_GAP_P,
      WR_GAP_S
   } wr_sel_type;

   typedef struct packed {
      logic       load_item;
      idx_op_type idx_op;
      logic       mem_wr;
      wr_sel_type wr_sel;
      logic       wr_at_pos;
      logic       q_acc;
      logic       load_rsp;
   } cmd_type;

   typedef struct packed {
      logic in_mode;
      logic in_invalid;
      logic rd_nonzero;
      logic idx_zero;
      logic idx_last;
      logic idx_at_pos;
      logic pos_last;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

/* sv/fgfq_if.sv */
// Valid/ready channel interfaces for the request and response words.
// Depends on fgfq_pkg for the field widths.
`default_nettype none
interface fgfq_req_if;
   import fgfq_pkg::*;
   logic              valid;
   logic              ready;
   logic              mode;
   logic [POS_W-1:0]  position;
   logic [SIZE_W-1:0] block_size;
   modport source (output valid, output mode, output position, output block_size,
                   input ready);
   modport sink   (input valid, input mode, input position, input block_size,
                   output ready);
endinterface

interface fgfq_rsp_if;
   logic valid;
   logic ready;
   logic fits;
   modport source (output valid, output fits, input ready);
   modport sink   (input valid, input fits, output ready);
endinterface
`default_nettype wire

/* sv/fgfq_datapath.sv */
// Datapath: gap memory, scan index, item registers, query accumulators, result register.
// Depends on fgfq_pkg; driven by fgfq_controller through cmd_type.
`default_nettype none
module fgfq_datapath #(
   parameter int POSITIONS = fgfq_pkg::POSITIONS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_mode,
   input  wire logic [fgfq_pkg::POS_W-1:0] req_position,
   input  wire logic [fgfq_pkg::SIZE_W-1:0] req_block_size,
   input  wire logic                       rsp_ready,
   output logic                            rsp_valid,
   output logic                            rsp_fits,
   input  wire fgfq_pkg::cmd_type          cmd,
   output fgfq_pkg::status_type            status
);
   import fgfq_pkg::*;

   localparam int PW    = $clog2(POSITIONS);
   localparam int EW    = (PW > POS_W ? PW : POS_W) + 1;
   localparam int CW    = (PW > SIZE_W ? PW : SIZE_W);
   localparam logic [EW-1:0] POS_LIM  = EW'(POSITIONS);
   localparam logic [PW-1:0] POS_LAST = PW'(POSITIONS - 1);

   // gap back to the predecessor for each obstacle; zero means no obstacle
   logic [PW-1:0]     gap_mem [POSITIONS];
   logic [PW-1:0]     rd_ff;
   logic [PW-1:0]     idx_ff, idx_in;
   logic [PW-1:0]     pos_ff, pos_in;
   logic [SIZE_W-1:0] size_ff;
   logic [PW-1:0]     max_ff, max_in;
   logic [PW-1:0]     last_ff, last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              fits_ff, fits_in;
   logic [EW-1:0]     in_ext;
   logic [PW-1:0]     in_sat;
   logic [PW-1:0]     wr_addr, wr_data;
   logic [PW-1:0]     stretch, best;

   assign in_ext = EW'(req_position);
   assign in_sat = (in_ext >= POS_LIM) ? POS_LAST : PW'(in_ext);

   always_comb begin
      case (cmd.idx_op)
         IDX_HOLD:   idx_in = idx_ff;
         IDX_ZERO:   idx_in = '0;
         IDX_POS:    idx_in = in_sat;
         IDX_POS_M1: idx_in = pos_ff - PW'(1);
         IDX_POS_P1: idx_in = pos_ff + PW'(1);
         IDX_INC:    idx_in = idx_ff + PW'(1);
         IDX_DEC:    idx_in = idx_ff - PW'(1);
         default:    idx_in = idx_ff;
      endcase
   end

   always_comb begin
      wr_addr = cmd.wr_at_pos ? pos_ff : idx_ff;
      case (cmd.wr_sel)
         WR_ZERO:  wr_data = '0;
         WR_GAP_P: wr_data = pos_ff - idx_ff;
         WR_GAP_S: wr_data = idx_ff - pos_ff;
         default:  wr_data = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         gap_mem[wr_addr] <= wr_data;
      end
      rd_ff <= gap_mem[idx_ff];
   end

   always_comb begin
      pos_in  = cmd.load_item ? in_sat : pos_ff;
      max_in  = max_ff;
      last_in = last_ff;
      if (cmd.load_item) begin
         max_in  = '0;
         last_in = '0;
      end else if (cmd.q_acc && (rd_ff != '0)) begin
         max_in  = (rd_ff > max_ff) ? rd_ff : max_ff;
         last_in = idx_ff;
      end
   end

   assign stretch = pos_ff - last_ff;
   assign best    = (stretch > max_ff) ? stretch : max_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      fits_in      = fits_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         fits_in      = (CW'(best) >= CW'(size_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         pos_ff       <= '0;
         max_ff       <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         pos_ff       <= pos_in;
         max_ff       <= max_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.load_item) begin
         size_ff <= req_block_size;
      end
      fits_ff <= fits_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_fits  = fits_ff;

   always_comb begin
      status.in_mode    = req_mode;
      status.in_invalid = (in_ext == '0) || (in_ext >= POS_LIM);
      status.rd_nonzero = (rd_ff != '0);
      status.idx_zero   = (idx_ff == '0);
      status.idx_last   = (idx_ff == POS_LAST);
      status.idx_at_pos = (idx_ff == pos_ff);
      status.pos_last   = (pos_ff == POS_LAST);
      status.out_free   = !rsp_valid_ff || rsp_ready;
   end

`ifndef SYNTH
   a_last_le_x: assert property (@(posedge clock) disable iff (reset)
      last_ff <= pos_ff) else $error("last obstacle beyond query limit");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(fits_ff)))
      else $error("pending result overwritten");
   a_rsp_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded while register busy");
`endif

endmodule
`default_nettype wire

/* sv/fgfq_controller.sv */
// Controller state machine: clearing pass, place sequence and query scan.
// Depends on fgfq_pkg; commands fgfq_datapath.
`default_nettype none
module fgfq_controller (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire fgfq_pkg::status_type status,
   output fgfq_pkg::cmd_type         cmd
);
   import fgfq_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '{load_item: 1'b0, idx_op: IDX_HOLD, mem_wr: 1'b0, wr_sel: WR_ZERO,
                    wr_at_pos: 1'b0, q_acc: 1'b0, load_rsp: 1'b0};
      case (state_ff)
         ST_CLEAR: begin
            cmd.mem_wr = 1'b1;
            cmd.idx_op = IDX_INC;
            if (status.idx_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               if (status.in_mode) begin
                  cmd.idx_op = IDX_ZERO;
                  state_in   = ST_Q_RD;
               end else if (!status.in_invalid) begin
                  cmd.idx_op = IDX_POS;
                  state_in   = ST_PC_RD;
               end
            end
         end
         ST_PC_RD: state_in = ST_PC_EV;
         ST_PC_EV: begin
            if (status.rd_nonzero) begin
               state_in = ST_IDLE;
            end else begin
               cmd.idx_op = IDX_POS_M1;
               state_in   = ST_DN_RD;
            end
         end
         ST_DN_RD: state_in = ST_DN_EV;
         ST_DN_EV: begin
            // position 0 always stops the downward search
            if (status.rd_nonzero || status.idx_zero) begin
               state_in = ST_WR_P;
            end else begin
               cmd.idx_op = IDX_DEC;
               state_in   = ST_DN_RD;
            end
         end
         ST_WR_P: begin
            cmd.mem_wr    = 1'b1;
            cmd.wr_sel    = WR_GAP_P;
            cmd.wr_at_pos = 1'b1;
            if (status.pos_last) begin
               state_in = ST_IDLE;
            end else begin
               cmd.idx_op = IDX_POS_P1;
               state_in   = ST_UP_RD;
            end
         end
         ST_UP_RD: state_in = ST_UP_EV;
         ST_UP_EV: begin
            if (status.rd_nonzero) begin
               state_in = ST_WR_S;
            end else if (status.idx_last) begin
               state_in = ST_IDLE;
            end else begin
               cmd.idx_op = IDX_INC;
               state_in   = ST_UP_RD;
            end
         end
         ST_WR_S: begin
            cmd.mem_wr = 1'b1;
            cmd.wr_sel = WR_GAP_S;
            state_in   = ST_IDLE;
         end
         ST_Q_RD: state_in = ST_Q_EV;
         ST_Q_EV: begin
            cmd.q_acc = 1'b1;
            if (status.idx_at_pos) begin
               state_in = ST_RESP;
            end else begin
               cmd.idx_op = IDX_INC;
               state_in   = ST_Q_RD;
            end
         end
         ST_RESP: begin
            // hold until the result register is free
            if (status.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

`ifndef SYNTH
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (state_ff == ST_IDLE)) else $error("ready outside idle");
   a_dn_loop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DN_EV && !status.rd_nonzero && !status.idx_zero)
      |=> (state_ff == ST_DN_RD)) else $error("downward search left early");
   a_wr_p_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WR_P) |=> (state_ff == ST_IDLE || state_ff == ST_UP_RD))
      else $error("bad step after gap write");
`endif

endmodule
`default_nettype wire

/* sv/free_gap_fit_query_unit.sv */
// Free gap fit query unit. Keeps obstacle positions on a line from 0 (always an
// obstacle) and answers whether a free segment of at least block_size lies
// within 0..x. Each obstacle holds its gap to its predecessor in a memory of
// POSITIONS entries with separate write and read addresses. Every search walks
// that memory one entry at a time (address, then registered read data), so the
// walk length sets the time for a word. A query walks entries 0..x and then
// waits until the result register is free. A place walks down to its
// predecessor, writes its gap, then walks up to its successor and writes the
// successor's gap; with no successor the upward walk runs to the line's end
// and skips the successor write. A place at position 0 or beyond the line is
// ignored, and a place at an existing obstacle changes nothing. After reset a
// clearing pass over all POSITIONS entries runs before the first word is
// accepted. One word is in work at a time; a waiting result does not block
// acceptance of the next word.
`default_nettype none
module free_gap_fit_query_unit #(
   parameter int POSITIONS = fgfq_pkg::POSITIONS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   fgfq_req_if.sink   req_chan,
   fgfq_rsp_if.source rsp_chan
);
   import fgfq_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       req_ready;
   logic       rsp_valid;
   logic       rsp_fits;

   fgfq_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   fgfq_datapath #(.POSITIONS(POSITIONS)) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_mode       (req_chan.mode),
      .req_position   (req_chan.position),
      .req_block_size (req_chan.block_size),
      .rsp_ready      (rsp_chan.ready),
      .rsp_valid      (rsp_valid),
      .rsp_fits       (rsp_fits),
      .cmd            (cmd),
      .status         (status)
   );

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;
   assign rsp_chan.fits  = rsp_fits;

endmodule
`default_nettype wire

/* dv/free_gap_fit_query_unit_tb.sv */
// Self-checking bench for the free gap fit query unit: place and query words
// with a running obstacle map that predicts every fits answer.
// Depends on fgfq_pkg, fgfq_if and free_gap_fit_query_unit.
`default_nettype none
module free_gap_fit_query_unit_tb;
   import fgfq_pkg::*;

   localparam int LINE_LEN   = POSITIONS_DEF;
   localparam int CYCLE_CAP  = 12_000_000;
   localparam int PAUSE_AT   = 330;
   localparam int HOLD_AT    = 40;
   localparam int HOLD_LEN   = 400;
   localparam int CALM_TAIL  = 80;
   localparam int SETTLE     = 5000;

   typedef struct packed {
      logic              mode;
      logic [POS_W-1:0]  position;
      logic [SIZE_W-1:0] block_size;
   } gap_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fgfq_req_if req_if ();
   fgfq_rsp_if rsp_if ();

   free_gap_fit_query_unit #(.POSITIONS(LINE_LEN)) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always #6 clock = ~clock;

   gap_word_type pending_words[$];
   logic         fits_due[$];
   logic         obstacle_seen[LINE_LEN];
   gap_word_type word_now;
   int           errors = 0;
   int           words_sent = 0;
   int           fits_seen = 0;
   int           place_count = 0;
   int           query_count = 0;
   int           fit_ones = 0;
   int           cycles = 0;
   bit           calm = 1'b0;

   initial begin
      req_if.valid      = 1'b0;
      req_if.mode       = 1'b0;
      req_if.position   = '0;
      req_if.block_size = '0;
      rsp_if.ready      = 1'b0;
      foreach (obstacle_seen[i]) obstacle_seen[i] = 1'b0;
      obstacle_seen[0] = 1'b1;
   end

   // largest free segment within 0..x, compared with the block size
   function automatic logic block_fits(int x, int size);
      int last;
      int widest;
      last = 0;
      widest = 0;
      for (int p = 1; p <= x; p++) begin
         if (obstacle_seen[p]) begin
            if (p - last > widest) widest = p - last;
            last = p;
         end
      end
      if (x - last > widest) widest = x - last;
      return widest >= size;
   endfunction

   function automatic gap_word_type make_word(int m, int p, int s);
      gap_word_type w;
      w.mode = m[0];
      w.position = p[POS_W-1:0];
      w.block_size = s[SIZE_W-1:0];
      return w;
   endfunction

   task automatic queue_word(int m, int p, int s);
      pending_words.insert(pending_words.size(), make_word(m, p, s));
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("free_gap_fit_query_unit: mismatch");
         $finish;
      end
   end

   // driver
   int gap_left = 0;
   always @(posedge clock) begin : drive_words
      bit fire;
      bit keep;
      fire = req_if.valid && req_if.ready;
      keep = req_if.valid && !fire;
      if (fire) begin
         words_sent++;
         if (word_now.mode) begin
            query_count++;
            fits_due.insert(fits_due.size(),
                            block_fits(int'(word_now.position), int'(word_now.block_size)));
         end else begin
            place_count++;
            obstacle_seen[word_now.position] = 1'b1;
         end
      end
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!keep) begin
         if (gap_left > 0) begin
            gap_left--;
            req_if.valid <= 1'b0;
         end else if (words_sent == PAUSE_AT && fits_due.size() != 0) begin
            // hold until every answer so far has come back
            req_if.valid <= 1'b0;
         end else if (pending_words.size() != 0) begin
            word_now = pending_words.pop_front();
            req_if.mode       <= word_now.mode;
            req_if.position   <= word_now.position;
            req_if.block_size <= word_now.block_size;
            req_if.valid      <= 1'b1;
            calm = pending_words.size() < CALM_TAIL;
            if (!calm && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 14);
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // monitor
   int stall_left = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   always @(posedge clock) begin : watch_fits
      logic want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         fits_seen++;
         if (rsp_if.fits) fit_ones++;
         if (fits_due.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual fits=%0b", $time,
                     rsp_if.fits);
            errors++;
         end else begin
            want = fits_due.pop_front();
            if (rsp_if.fits !== want) begin
               $display("%0t: fits expected %0b actual %0b", $time, want, rsp_if.fits);
               errors++;
            end
         end
      end
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (!hold_done && fits_seen == HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_LEN;
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
         if (!calm && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 14);
      end
   end

   initial begin : stimulus
      int p;
      int s;
      // directed: empty line, limit zero, size zero, ignored places
      queue_word(1, 0, 0);
      queue_word(1, 0, 1);
      queue_word(1, 1023, 1023);
      queue_word(1, 1023, 0);
      queue_word(0, 0, 1023);
      queue_word(0, 1023, 0);
      queue_word(0, 1, 5);
      queue_word(0, 1, 5);
      queue_word(0, 512, 0);
      queue_word(1, 1023, 511);
      queue_word(1, 1023, 512);
      queue_word(1, 511, 510);
      queue_word(1, 511, 511);
      queue_word(1, 600, 100);
      queue_word(0, 2, 0);
      queue_word(1, 2, 1);
      queue_word(1, 2, 2);
      queue_word(1, 0, 1023);
      queue_word(1, 1022, 510);
      queue_word(1, 1023, 1);
      for (int n = 0; n < 630; n++) begin
         // mostly short reach to keep the walks brief, some across the line
         if ($urandom_range(0, 9) < 7) p = $urandom_range(0, 127);
         else p = $urandom_range(0, 1023);
         case ($urandom_range(0, 3))
            0: s = $urandom_range(0, 1023);
            1: s = $urandom_range(0, 8);
            default: s = $urandom_range(0, 64);
         endcase
         queue_word($urandom_range(0, 1), p, s);
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      while (pending_words.size() != 0 || req_if.valid || fits_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      $display("ran %0d places and %0d queries, %0d answers checked (%0d fits)",
               place_count, query_count, fits_seen, fit_ones);
      if (errors == 0 && fits_due.size() == 0) begin
         $display("free_gap_fit_query_unit: match");
      end else begin
         $display("free_gap_fit_query_unit: mismatch");
      end
      $finish;
   end

endmodule
`default_nettype wire

/* sim.f */
sv/fgfq_pkg.sv
sv/fgfq_if.sv
sv/fgfq_datapath.sv
sv/fgfq_controller.sv
sv/free_gap_fit_query_unit.sv
dv/free_gap_fit_query_unit_tb.sv
